// File: design/ccac_pkg.sv
`timescale 1ns / 1ps

package ccac_pkg;

  // Default number of cache slots.
  localparam int unsigned DEF_CACHE_ENTRIES = 16;

  // Opcodes of an input beat.
  localparam logic [2:0] OP_CALL   = 3'd0;
  localparam logic [2:0] OP_EXCL   = 3'd1;
  localparam logic [2:0] OP_INIT   = 3'd2;
  localparam logic [2:0] OP_FLUSH  = 3'd3;
  localparam logic [2:0] OP_REPORT = 3'd4;

  // Kinds of an output beat.
  localparam logic [1:0] KIND_NONE   = 2'd0;
  localparam logic [1:0] KIND_ENTRY  = 2'd1;
  localparam logic [1:0] KIND_REPORT = 2'd2;
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [15:0] caller_id;
    logic [15:0] callee_id;
    logic [15:0] call_line;
    logic [47:0] amount;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] out_caller;
    logic [15:0] out_callee;
    logic        out_exclusive;
    logic [15:0] out_line;
    logic [31:0] out_calls;
    logic [47:0] out_cost;
    logic [31:0] hit_count;
    logic [31:0] miss_count;
    logic        last;
  } out_item_t;

  // One cache slot as it is held in memory.
  typedef struct packed {
    logic [15:0] caller;
    logic [15:0] callee;
    logic        excl;
    logic [15:0] line;
    logic [31:0] calls;
    logic [47:0] cost;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

  // Increment that sticks at the all-ones value.
  function automatic logic [31:0] sat_inc32(logic [31:0] v);
    return (v == '1) ? v : v + 32'd1;
  endfunction

  // Result with no data: everything zero except the last flag.
  function automatic out_item_t empty_res();
    out_item_t r;
    r      = '0;
    r.kind = KIND_NONE;
    r.last = 1'b1;
    return r;
  endfunction

  // Result that carries one slot; exclusive lines show no callee and no calls.
  function automatic out_item_t entry_res(entry_t e, logic is_last);
    out_item_t r;
    r               = '0;
    r.kind          = KIND_ENTRY;
    r.out_caller    = e.caller;
    r.out_exclusive = e.excl;
    r.out_callee    = e.excl ? 16'd0 : e.callee;
    r.out_line      = e.line;
    r.out_calls     = e.excl ? 32'd0 : e.calls;
    r.out_cost      = e.cost;
    r.last          = is_last;
    return r;
  endfunction

endpackage

// File: design/call_cost_aggregation_cache_top.sv
`timescale 1ns / 1ps

// Call cost aggregation cache.
// Input channel in_valid_i / in_ready_o / in_item_i carries one request beat:
// call cost, exclusive cost, counter init, flush or totals report. Output
// channel out_valid_o / out_ready_i / out_item_o carries result beats; the
// final beat for a request has last set.
// One request is worked at a time. Slots live in a memory with one write port
// and one registered read port, and a lookup reads one slot per cycle. A call
// or exclusive request compares the filled slots in order; a miss fills a free
// slot, or with all slots filled evicts the slot under the replace pointer and
// returns it as a result beat. A flush emits each held slot as a beat. Results
// pass through an output register.
// Reset empties the cache and clears the running total, the previous counter
// reading and the hit and miss counters; slot contents are not cleared.
// When the receiver stalls, the output register holds its beat and the
// sequencer waits with the next result, so no input is taken until the
// current request's results have all moved into the output register.
module call_cost_aggregation_cache_top #(
  parameter int unsigned CACHE_ENTRIES = ccac_pkg::DEF_CACHE_ENTRIES
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  ccac_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output ccac_pkg::out_item_t out_item_o
);

  import ccac_pkg::*;

  localparam int unsigned IDX_W = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;

  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  entry_t           ram_wdata;
  logic             ram_re;
  logic [IDX_W-1:0] ram_raddr;
  entry_t           ram_rdata;
  logic [ENTRY_W-1:0] ram_rdata_raw;

  logic       res_valid;
  logic       res_ready;
  out_item_t  res;

  logic       out_valid_q, out_valid_d;
  out_item_t  out_item_q, out_item_d;

  // Slot storage.
  ccac_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (CACHE_ENTRIES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata_raw)
  );

  assign ram_rdata = entry_t'(ram_rdata_raw);

  // Lookup and update sequencer.
  ccac_core #(
    .CACHE_ENTRIES (CACHE_ENTRIES)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata)
  );

  // Output register: takes a new beat when empty or when its beat leaves.
  assign res_ready = !out_valid_q || out_ready_i;

  always_comb begin
    out_valid_d = out_valid_q;
    out_item_d  = out_item_q;
    if (res_valid && res_ready) begin
      out_valid_d = 1'b1;
      out_item_d  = res;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      out_item_q  <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      out_item_q  <= out_item_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

// File: design/ccac_ram.sv
`timescale 1ns / 1ps

module ccac_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // One write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: design/ccac_core.sv
`timescale 1ns / 1ps

module ccac_core #(
  parameter int unsigned CACHE_ENTRIES = ccac_pkg::DEF_CACHE_ENTRIES,
  localparam int unsigned IDX_W = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1,
  localparam int unsigned CNT_W = $clog2(CACHE_ENTRIES + 1)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  ccac_pkg::in_item_t  in_item_i,
  output logic                res_valid_o,
  input  logic                res_ready_i,
  output ccac_pkg::out_item_t res_o,
  output logic                ram_we_o,
  output logic [IDX_W-1:0]    ram_waddr_o,
  output ccac_pkg::entry_t    ram_wdata_o,
  output logic                ram_re_o,
  output logic [IDX_W-1:0]    ram_raddr_o,
  input  ccac_pkg::entry_t    ram_rdata_i
);

  import ccac_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_MISS,
    ST_EVICT,
    ST_FL_RD,
    ST_FL_OUT,
    ST_EMIT
  } state_e;

  state_e           state_q, state_d;
  entry_t           key_q, key_d;
  logic [CNT_W-1:0] idx_q, idx_d;
  logic [IDX_W-1:0] cmp_q, cmp_d;
  logic             pend_q, pend_d;
  logic [CNT_W-1:0] fill_q, fill_d;
  logic [IDX_W-1:0] rp_q, rp_d;
  logic [47:0]      prev_q, prev_d;
  logic [47:0]      total_q, total_d;
  logic [31:0]      hits_q, hits_d;
  logic [31:0]      misses_q, misses_d;
  out_item_t        res_q, res_d;
  logic             flush_q, flush_d;

  logic             issue;
  logic             key_hit;
  logic             cmp_last;
  logic             fl_last;
  logic             full;
  logic [47:0]      diff;
  entry_t           upd;

  // Compare of the slot read in the previous cycle against the pending key.
  assign key_hit = (ram_rdata_i.caller == key_q.caller) &&
                   (ram_rdata_i.callee == key_q.callee) &&
                   (ram_rdata_i.excl == key_q.excl) &&
                   (ram_rdata_i.line == key_q.line);
  assign cmp_last = ((CNT_W'(cmp_q) + CNT_W'(1)) == fill_q);
  assign fl_last  = ((idx_q + CNT_W'(1)) == fill_q);
  assign full     = (fill_q == CNT_W'(CACHE_ENTRIES));
  assign diff     = in_item_i.amount - prev_q;

  // Accumulated slot on a hit.
  always_comb begin
    upd       = ram_rdata_i;
    upd.calls = sat_inc32(ram_rdata_i.calls);
    upd.cost  = ram_rdata_i.cost + key_q.cost;
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign res_valid_o = (state_q == ST_EMIT);
  assign res_o       = res_q;

  // Sequencer: search, fill, evict, flush and result hand-off.
  always_comb begin
    state_d     = state_q;
    key_d       = key_q;
    idx_d       = idx_q;
    cmp_d       = cmp_q;
    pend_d      = pend_q;
    fill_d      = fill_q;
    rp_d        = rp_q;
    prev_d      = prev_q;
    total_d     = total_q;
    hits_d      = hits_q;
    misses_d    = misses_q;
    res_d       = res_q;
    flush_d     = flush_q;
    issue       = 1'b0;
    ram_we_o    = 1'b0;
    ram_waddr_o = cmp_q;
    ram_wdata_o = key_q;
    ram_re_o    = 1'b0;
    ram_raddr_o = idx_q[IDX_W-1:0];

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          flush_d = 1'b0;
          idx_d   = '0;
          pend_d  = 1'b0;
          case (in_item_i.opcode)
            OP_CALL: begin
              key_d.caller = in_item_i.caller_id;
              key_d.callee = in_item_i.callee_id;
              key_d.excl   = 1'b0;
              key_d.line   = in_item_i.call_line;
              key_d.calls  = 32'd1;
              key_d.cost   = in_item_i.amount;
              state_d      = (fill_q == '0) ? ST_MISS : ST_SEARCH;
            end
            OP_EXCL: begin
              key_d.caller = in_item_i.caller_id;
              key_d.callee = 16'd0;
              key_d.excl   = 1'b1;
              key_d.line   = in_item_i.call_line;
              key_d.calls  = 32'd1;
              key_d.cost   = diff;
              total_d      = total_q + diff;
              prev_d       = in_item_i.amount;
              state_d      = (fill_q == '0) ? ST_MISS : ST_SEARCH;
            end
            OP_INIT: begin
              prev_d  = in_item_i.amount;
              res_d   = empty_res();
              state_d = ST_EMIT;
            end
            OP_FLUSH: begin
              if (fill_q == '0) begin
                res_d   = empty_res();
                state_d = ST_EMIT;
              end else begin
                state_d = ST_FL_RD;
              end
            end
            OP_REPORT: begin
              res_d            = '0;
              res_d.kind       = KIND_REPORT;
              res_d.out_cost   = total_q;
              res_d.hit_count  = hits_q;
              res_d.miss_count = misses_q;
              res_d.last       = 1'b1;
              state_d          = ST_EMIT;
            end
            default: begin
              res_d   = empty_res();
              state_d = ST_EMIT;
            end
          endcase
        end
      end

      // One slot read per cycle; the compare comes in the cycle after the read.
      ST_SEARCH: begin
        issue       = (idx_q < fill_q);
        ram_re_o    = issue;
        ram_raddr_o = idx_q[IDX_W-1:0];
        pend_d      = issue;
        cmp_d       = idx_q[IDX_W-1:0];
        idx_d       = idx_q + CNT_W'(issue);
        if (pend_q) begin
          if (key_hit) begin
            ram_we_o    = 1'b1;
            ram_waddr_o = cmp_q;
            ram_wdata_o = upd;
            hits_d      = sat_inc32(hits_q);
            res_d       = empty_res();
            state_d     = ST_EMIT;
          end else if (cmp_last) begin
            state_d = ST_MISS;
          end
        end
      end

      // Fill a free slot, or read the victim under the replace pointer.
      ST_MISS: begin
        misses_d = sat_inc32(misses_q);
        if (!full) begin
          ram_we_o    = 1'b1;
          ram_waddr_o = fill_q[IDX_W-1:0];
          ram_wdata_o = key_q;
          fill_d      = fill_q + CNT_W'(1);
          res_d       = empty_res();
          state_d     = ST_EMIT;
        end else begin
          ram_re_o    = 1'b1;
          ram_raddr_o = rp_q;
          state_d     = ST_EVICT;
        end
      end

      ST_EVICT: begin
        res_d       = entry_res(ram_rdata_i, 1'b1);
        ram_we_o    = 1'b1;
        ram_waddr_o = rp_q;
        ram_wdata_o = key_q;
        rp_d        = (rp_q == IDX_W'(CACHE_ENTRIES - 1)) ? '0 : rp_q + IDX_W'(1);
        state_d     = ST_EMIT;
      end

      ST_FL_RD: begin
        ram_re_o    = 1'b1;
        ram_raddr_o = idx_q[IDX_W-1:0];
        state_d     = ST_FL_OUT;
      end

      ST_FL_OUT: begin
        res_d   = entry_res(ram_rdata_i, fl_last);
        flush_d = !fl_last;
        if (fl_last) begin
          fill_d = '0;
          rp_d   = '0;
        end
        state_d = ST_EMIT;
      end

      ST_EMIT: begin
        if (res_ready_i) begin
          if (flush_q) begin
            idx_d   = idx_q + CNT_W'(1);
            state_d = ST_FL_RD;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      key_q    <= '0;
      idx_q    <= '0;
      cmp_q    <= '0;
      pend_q   <= 1'b0;
      fill_q   <= '0;
      rp_q     <= '0;
      prev_q   <= '0;
      total_q  <= '0;
      hits_q   <= '0;
      misses_q <= '0;
      res_q    <= '0;
      flush_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      key_q    <= key_d;
      idx_q    <= idx_d;
      cmp_q    <= cmp_d;
      pend_q   <= pend_d;
      fill_q   <= fill_d;
      rp_q     <= rp_d;
      prev_q   <= prev_d;
      total_q  <= total_d;
      hits_q   <= hits_d;
      misses_q <= misses_d;
      res_q    <= res_d;
      flush_q  <= flush_d;
    end
  end

endmodule

// File: design/ccac_chk.sv
`timescale 1ns / 1ps

module ccac_chk (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input ccac_pkg::in_item_t  in_item_i,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input ccac_pkg::out_item_t out_item_o
);

  import ccac_pkg::*;

  // A result beat stays offered until it is taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_item_o))
    else $error("output beat dropped or changed while stalled");

  // The unused kind code never shows up.
  a_kind_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_item_o.kind != KIND_UNUSED)
    else $error("output beat with unused kind");

  // A report is always the single, final beat of its request.
  a_report_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.kind == KIND_REPORT |-> out_item_o.last)
    else $error("report beat without last");

  // Counters appear only on a report beat.
  a_counts_report: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.kind != KIND_REPORT |->
      out_item_o.hit_count == '0 && out_item_o.miss_count == '0)
    else $error("hit or miss count on a non-report beat");

  // An empty beat ends its request and carries no cost.
  a_empty_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.kind == KIND_NONE |->
      out_item_o.last && out_item_o.out_cost == '0 && out_item_o.out_calls == '0)
    else $error("empty beat with data or without last");

endmodule

bind call_cost_aggregation_cache_top ccac_chk u_ccac_chk (.*);

// File: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import ccac_pkg::*;

  localparam int unsigned SLOTS       = DEF_CACHE_ENTRIES;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned CALM_TAIL   = 60;
  localparam int unsigned RAND_BEATS  = 400;

  // Opcodes the block treats as no-ops.
  localparam logic [2:0] OP_SPARE_LO = 3'd5;
  localparam logic [2:0] OP_SPARE_HI = 3'd7;

  // A request waiting for the driver; hold makes it wait for all results first.
  typedef struct {
    in_item_t beat;
    bit       hold;
  } request_t;

  logic      clk_i     = 1'b0;
  logic      rst_ni    = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready_o;
  in_item_t  in_item   = '0;
  logic      out_valid_o;
  logic      out_ready = 1'b0;
  out_item_t out_item_o;

  request_t  requests_q[$];
  out_item_t results_due[$];
  int        results_predicted = 0;
  int        results_seen      = 0;
  int        mismatches        = 0;
  int        cycles            = 0;

  // Shadow copy of the cache and its counters.
  entry_t      shadow_slots [SLOTS];
  int unsigned shadow_fill    = 0;
  int unsigned shadow_rr      = 0;
  logic [47:0] shadow_prev_rd = '0;
  logic [47:0] shadow_total   = '0;
  logic [31:0] shadow_hits    = '0;
  logic [31:0] shadow_misses  = '0;

  // Driver and monitor bookkeeping.
  logic        idle_on   = 1'b0;
  int unsigned gap_left  = 0;
  int unsigned stall_left = 0;
  int unsigned phase_cnt = 0;
  logic        offer;
  in_item_t    next_item;
  request_t    staged;
  out_item_t   want;

  call_cost_aggregation_cache_top uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready),
    .out_item_o (out_item_o)
  );

  always #10 clk_i = ~clk_i;

  // A result with no data carries only the last flag.
  function automatic out_item_t none_beat();
    out_item_t r;
    r      = '0;
    r.kind = KIND_NONE;
    r.last = 1'b1;
    return r;
  endfunction

  // A result that emits one slot of the shadow cache.
  function automatic out_item_t slot_beat(int unsigned s, logic lst);
    out_item_t r;
    r               = '0;
    r.kind          = KIND_ENTRY;
    r.out_caller    = shadow_slots[s].caller;
    r.out_exclusive = shadow_slots[s].excl;
    if (!shadow_slots[s].excl) begin
      r.out_callee = shadow_slots[s].callee;
      r.out_calls  = shadow_slots[s].calls;
    end
    r.out_line = shadow_slots[s].line;
    r.out_cost = shadow_slots[s].cost;
    r.last     = lst;
    return r;
  endfunction

  function automatic void expect_beat(out_item_t r);
    results_due.push_back(r);
    results_predicted++;
  endfunction

  // Search the shadow cache; accumulate on a hit, fill or evict on a miss.
  function automatic void cache_lookup(logic [15:0] caller, logic [15:0] callee,
                                       logic excl, logic [15:0] line,
                                       logic [47:0] cost);
    int          hit_at;
    int unsigned slot;
    hit_at = -1;
    for (int unsigned i = 0; i < shadow_fill; i++) begin
      if (hit_at < 0 && shadow_slots[i].caller == caller &&
          shadow_slots[i].callee == callee && shadow_slots[i].excl == excl &&
          shadow_slots[i].line == line) begin
        hit_at = i;
      end
    end
    if (hit_at >= 0) begin
      shadow_hits = (shadow_hits == '1) ? shadow_hits : shadow_hits + 32'd1;
      if (shadow_slots[hit_at].calls != '1) begin
        shadow_slots[hit_at].calls = shadow_slots[hit_at].calls + 32'd1;
      end
      shadow_slots[hit_at].cost = shadow_slots[hit_at].cost + cost;
      expect_beat(none_beat());
      return;
    end
    shadow_misses = (shadow_misses == '1) ? shadow_misses : shadow_misses + 32'd1;
    if (shadow_fill < SLOTS) begin
      slot = shadow_fill;
      shadow_fill++;
      expect_beat(none_beat());
    end else begin
      slot = shadow_rr;
      expect_beat(slot_beat(slot, 1'b1));
      shadow_rr = (slot + 1) % SLOTS;
    end
    shadow_slots[slot].caller = caller;
    shadow_slots[slot].callee = callee;
    shadow_slots[slot].excl   = excl;
    shadow_slots[slot].line   = line;
    shadow_slots[slot].calls  = 32'd1;
    shadow_slots[slot].cost   = cost;
  endfunction

  // Work out every result that one accepted request causes.
  function automatic void model_request(in_item_t b);
    logic [47:0] diff;
    out_item_t   r;
    case (b.opcode)
      OP_CALL: begin
        cache_lookup(b.caller_id, b.callee_id, 1'b0, b.call_line, b.amount);
      end
      OP_EXCL: begin
        diff           = b.amount - shadow_prev_rd;
        shadow_total   = shadow_total + diff;
        shadow_prev_rd = b.amount;
        cache_lookup(b.caller_id, 16'd0, 1'b1, b.call_line, diff);
      end
      OP_INIT: begin
        shadow_prev_rd = b.amount;
        expect_beat(none_beat());
      end
      OP_FLUSH: begin
        if (shadow_fill == 0) begin
          expect_beat(none_beat());
        end
        for (int unsigned i = 0; i < shadow_fill; i++) begin
          expect_beat(slot_beat(i, i + 1 == shadow_fill));
        end
        shadow_fill = 0;
        shadow_rr   = 0;
      end
      OP_REPORT: begin
        r            = '0;
        r.kind       = KIND_REPORT;
        r.out_cost   = shadow_total;
        r.hit_count  = shadow_hits;
        r.miss_count = shadow_misses;
        r.last       = 1'b1;
        expect_beat(r);
      end
      default: begin
        expect_beat(none_beat());
      end
    endcase
  endfunction

  function automatic string beat_text(out_item_t b);
    return $sformatf({"kind=%0d caller=%h callee=%h excl=%0d line=%h calls=%0d",
                      " cost=%h hits=%0d misses=%0d last=%0d"},
                     b.kind, b.out_caller, b.out_callee, b.out_exclusive,
                     b.out_line, b.out_calls, b.out_cost, b.hit_count,
                     b.miss_count, b.last);
  endfunction

  function automatic logic [47:0] rand48();
    logic [63:0] w;
    w = {$urandom(), $urandom()};
    return w[47:0];
  endfunction

  function automatic void add_request(logic [2:0] op, logic [15:0] caller,
                                      logic [15:0] callee, logic [15:0] line,
                                      logic [47:0] amount, bit hold);
    request_t q;
    q.beat.opcode    = op;
    q.beat.caller_id = caller;
    q.beat.callee_id = callee;
    q.beat.call_line = line;
    q.beat.amount    = amount;
    q.hold           = hold;
    requests_q.push_back(q);
  endfunction

  // Driver: offer the next request, hold it until taken, idle in bursts.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      in_item  <= '0;
      idle_on  <= 1'b0;
    end else begin
      offer     = in_valid;
      next_item = in_item;
      if (in_valid && in_ready_o) begin
        model_request(in_item);
        offer = 1'b0;
      end
      if (!offer) begin
        if (gap_left != 0) begin
          gap_left--;
        end else if (requests_q.size() != 0 &&
                     (!requests_q[0].hold || results_predicted == results_seen)) begin
          if (idle_on && $urandom_range(0, 3) == 0) begin
            gap_left = $urandom_range(0, 10);
          end else begin
            staged    = requests_q.pop_front();
            next_item = staged.beat;
            offer     = 1'b1;
          end
        end
      end
      in_valid <= offer;
      in_item  <= next_item;
      // Idling comes and goes in phases and stops for the tail of the run.
      phase_cnt++;
      if (requests_q.size() <= CALM_TAIL) begin
        idle_on <= 1'b0;
      end else if (phase_cnt % 150 == 0) begin
        idle_on <= ($urandom_range(0, 3) != 0);
      end
    end
  end

  // Monitor: check each result beat against the oldest expectation.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready    <= 1'b0;
      results_seen <= 0;
    end else begin
      if (out_valid_o && out_ready) begin
        results_seen <= results_seen + 1;
        if (results_due.size() == 0) begin
          if (mismatches < 10) begin
            $display("unexpected result beat: %s", beat_text(out_item_o));
          end
          mismatches++;
        end else begin
          want = results_due.pop_front();
          if (out_item_o !== want) begin
            if (mismatches < 10) begin
              $display("result beat %0d mismatch", results_seen);
              $display("  expected %s", beat_text(want));
              $display("  actual   %s", beat_text(out_item_o));
            end
            mismatches++;
          end
        end
      end
      if (stall_left != 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        stall_left = $urandom_range(0, 10);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Stimulus, reset and end of run.
  initial begin
    logic [15:0] key_caller [24];
    logic [15:0] key_callee [24];
    logic [15:0] key_line [24];
    int unsigned pool_n;
    int unsigned k;
    int unsigned pick;
    bit          refill;
    logic [2:0]  op;
    logic [15:0] caller;
    logic [15:0] callee;
    logic [15:0] line;
    logic [47:0] amount;
    logic [47:0] reading;

    // Directed opening: empty cache, extremes, wraps, spare opcodes, eviction.
    add_request(OP_FLUSH, 16'h0000, 16'h0000, 16'h0000, '0, 1'b0);
    add_request(OP_REPORT, 16'hFFFF, 16'hFFFF, 16'hFFFF, '1, 1'b0);
    add_request(OP_SPARE_LO, 16'hFFFF, 16'hFFFF, 16'hFFFF, '1, 1'b0);
    add_request(OP_SPARE_HI, 16'h0000, 16'h0000, 16'h0000, '0, 1'b0);
    add_request(OP_CALL, 16'h0000, 16'h0000, 16'h0000, '0, 1'b0);
    add_request(OP_CALL, 16'hFFFF, 16'hFFFF, 16'hFFFF, '1, 1'b0);
    // Hit whose cost wraps around to zero.
    add_request(OP_CALL, 16'hFFFF, 16'hFFFF, 16'hFFFF, 48'd1, 1'b0);
    // Exclusive lines ignore the callee; the second reading goes backward.
    add_request(OP_EXCL, 16'hFFFF, 16'h1234, 16'hFFFF, 48'd5, 1'b0);
    add_request(OP_EXCL, 16'hFFFF, 16'h0000, 16'hFFFF, 48'd2, 1'b0);
    // Same caller and line as a call line, but exclusive, so a separate slot.
    add_request(OP_EXCL, 16'h0000, 16'hABCD, 16'h0000, 48'd7, 1'b0);
    add_request(OP_INIT, 16'h5A5A, 16'hA5A5, 16'h3C3C, '1, 1'b0);
    add_request(OP_EXCL, 16'h0000, 16'h0000, 16'h0000, '0, 1'b0);
    add_request(OP_REPORT, 16'h0000, 16'h0000, 16'h0000, '0, 1'b0);
    // Fill the remaining slots, then one more miss evicts the oldest.
    for (k = 0; k < SLOTS - 3; k++) begin
      add_request(OP_CALL, 16'(k + 1), 16'h00FF, 16'(k), 48'(k), 1'b0);
    end
    add_request(OP_REPORT, 16'h0000, 16'h0000, 16'h0000, '0, 1'b0);
    add_request(OP_FLUSH, 16'h0000, 16'h0000, 16'h0000, '0, 1'b1);

    // Random part: mostly lookups over a small key pool so hits, fills and
    // evictions all happen, mixed with counter inits, flushes and reports.
    refill  = 1'b1;
    reading = '0;
    pool_n  = 1;
    for (k = 0; k < RAND_BEATS; k++) begin
      if (refill) begin
        pool_n = $urandom_range(2, 24);
        for (int unsigned j = 0; j < 24; j++) begin
          key_caller[j] = 16'($urandom());
          key_callee[j] = 16'($urandom());
          key_line[j]   = 16'($urandom());
        end
        refill = 1'b0;
      end
      pick = $urandom_range(0, 99);
      if (pick < 45) op = OP_CALL;
      else if (pick < 80) op = OP_EXCL;
      else if (pick < 84) op = OP_INIT;
      else if (pick < 89) op = OP_FLUSH;
      else if (pick < 96) op = OP_REPORT;
      else op = 3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));

      if ($urandom_range(0, 99) < 85) begin
        pick   = $urandom_range(0, pool_n - 1);
        caller = key_caller[pick];
        callee = key_callee[pick];
        line   = key_line[pick];
      end else begin
        caller = 16'($urandom());
        callee = 16'($urandom());
        line   = 16'($urandom());
      end

      case ($urandom_range(0, 9))
        0:       amount = rand48();
        1:       amount = '1;
        default: amount = 48'($urandom_range(0, 4095));
      endcase
      if (op == OP_EXCL) begin
        // Readings usually climb; sometimes they jump anywhere.
        if ($urandom_range(0, 9) == 0) reading = rand48();
        else reading = reading + 48'($urandom_range(0, 5000));
        amount = reading;
      end else if (op == OP_INIT) begin
        if ($urandom_range(0, 1) == 0) amount = rand48();
        reading = amount;
      end else if (op == OP_FLUSH) begin
        refill = ($urandom_range(0, 1) == 0);
      end
      add_request(op, caller, callee, line, amount, $urandom_range(0, 39) == 0);
    end

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (requests_q.size() != 0 || in_valid) @(negedge clk_i);
    while (results_predicted != results_seen) @(negedge clk_i);
    repeat (40) @(negedge clk_i);
    mismatches += results_due.size();
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// File: files.f
design/ccac_pkg.sv
design/ccac_ram.sv
design/ccac_core.sv
design/call_cost_aggregation_cache_top.sv
design/ccac_chk.sv
tb/tb_top.sv
